### hw/rtl/psfr_pkg.sv
// Shared types and constants for the power status frame receiver.
// No dependencies; imported by every other module of the block.
package psfr_pkg;

    // Configuration register indexes
    localparam logic CFG_SYNC = 1'b0;
    localparam logic CFG_DIR  = 1'b1;

    // Frame types that update status words
    localparam logic [7:0] KIND_STATUS   = 8'h00;
    localparam logic [7:0] KIND_ONOFF    = 8'h01;
    localparam logic [7:0] KIND_POWER    = 8'h04;
    localparam logic [7:0] KIND_CAPACITY = 8'h12;

    localparam logic [15:0] CAP_FULL = 16'd10000;

    localparam logic [1:0] CHARGE_CHARGING = 2'd0;
    localparam logic [1:0] CHARGE_FULL     = 2'd1;
    localparam logic [1:0] CHARGE_NO_BATT  = 2'd2;

    // Only these payload positions are ever read; each gets a slot register.
    localparam int KEEP_N = 12;
    localparam int KEEP_POS [KEEP_N] = '{0, 1, 2, 3, 4, 5, 10, 11, 12, 13, 16, 17};

    // Slot numbers of the kept positions
    localparam int SLOT_P0  = 0;
    localparam int SLOT_P1  = 1;
    localparam int SLOT_P2  = 2;
    localparam int SLOT_P3  = 3;
    localparam int SLOT_P4  = 4;
    localparam int SLOT_P5  = 5;
    localparam int SLOT_P10 = 6;
    localparam int SLOT_P11 = 7;
    localparam int SLOT_P12 = 8;
    localparam int SLOT_P13 = 9;
    localparam int SLOT_P16 = 10;
    localparam int SLOT_P17 = 11;

    typedef struct packed {
        logic        frame_done;
        logic        frame_ok;
        logic [15:0] power_state;
        logic [15:0] remaining_capacity;
        logic [15:0] on_off_state;
        logic [15:0] software_word_low;
        logic [15:0] software_word_high;
        logic        ac_present;
        logic        battery_present;
        logic [1:0]  charge_status;
    } t_result;

endpackage

### hw/rtl/power_status_frame_receiver_top.sv
// Power status frame receiver: parses received serial bytes into frames.
// Depends on psfr_pkg, psfr_parser and psfr_out_buf.
//
// Usage:
//   Input channel carries one received byte per transaction (i_in_valid,
//   o_in_stall, i_rx_byte). Every accepted byte yields exactly one result
//   on the output channel (o_out_valid, i_out_stall, o_frame_done ...).
//   o_frame_done/o_frame_ok flag the checksum byte ending a frame; the
//   status words and derived flags reflect all frames completed so far,
//   including the one ending with this byte.
//   Each result is registered in the output buffer. Throughput: one byte per
//   cycle while o_in_stall is low; the parser step is a single pass of
//   logic from the parse state registers to the result register.
//   When the receiver stalls, one further byte is taken into a skid
//   register, after which o_in_stall rises until the output drains.
//   Reset clears the parse state, kept payload bytes, status words and
//   both configuration registers (sync byte and direction code), and
//   empties the output buffer. Write configuration only while idle.
module power_status_frame_receiver_top #(
    parameter int MAX_PAYLOAD = 50
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_frame_done,
    output logic        o_frame_ok,
    output logic [15:0] o_power_state,
    output logic [15:0] o_remaining_capacity,
    output logic [15:0] o_on_off_state,
    output logic [15:0] o_software_word_low,
    output logic [15:0] o_software_word_high,
    output logic        o_ac_present,
    output logic        o_battery_present,
    output logic [1:0]  o_charge_status
);
    import psfr_pkg::*;

    logic    buf_full;
    logic    in_acc;
    t_result parse_res;
    t_result out_res;

    assign o_in_stall = buf_full;
    assign in_acc     = i_in_valid & ~buf_full;

    psfr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_acc       (in_acc),
        .i_rx_byte   (i_rx_byte),
        .o_result    (parse_res)
    );

    psfr_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_full   (buf_full),
        .i_result (parse_res),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_res)
    );

    assign o_frame_done         = out_res.frame_done;
    assign o_frame_ok           = out_res.frame_ok;
    assign o_power_state        = out_res.power_state;
    assign o_remaining_capacity = out_res.remaining_capacity;
    assign o_on_off_state       = out_res.on_off_state;
    assign o_software_word_low  = out_res.software_word_low;
    assign o_software_word_high = out_res.software_word_high;
    assign o_ac_present         = out_res.ac_present;
    assign o_battery_present    = out_res.battery_present;
    assign o_charge_status      = out_res.charge_status;

endmodule

### hw/rtl/psfr_parser.sv
// Frame parser: configuration registers, parse state, kept payload bytes
// and status words. Produces one result per accepted byte. Uses psfr_pkg.
module psfr_parser #(
    parameter int MAX_PAYLOAD = 50
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_acc,
    input  logic [7:0]        i_rx_byte,
    output psfr_pkg::t_result o_result
);
    import psfr_pkg::*;

    localparam int IW = $clog2(MAX_PAYLOAD + 1);

    localparam logic [2:0] PH_SYNC  = 3'd0;
    localparam logic [2:0] PH_DIR   = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_TYPE  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CHECK = 3'd5;

    logic [7:0]    r_sync_byte;
    logic [7:0]    r_dir_code;
    logic [2:0]    r_phase, n_phase;
    logic [7:0]    r_sum, n_sum;
    logic [IW-1:0] r_len, n_len;
    logic [IW-1:0] r_idx, n_idx;
    logic [7:0]    r_kind, n_kind;
    logic [7:0]    r_slot [KEEP_N];
    logic [7:0]    n_slot [KEEP_N];
    logic [15:0]   r_pwr, n_pwr;
    logic [15:0]   r_cap, n_cap;
    logic [15:0]   r_onoff, n_onoff;
    logic [15:0]   r_swlo, n_swlo;
    logic [15:0]   r_swhi, n_swhi;

    logic          done;
    logic          ok;
    logic [7:0]    len_raw;
    logic [7:0]    sum_add;
    logic [IW-1:0] idx_inc;

    assign len_raw = i_rx_byte - 8'd2;
    assign sum_add = r_sum + i_rx_byte;
    assign idx_inc = r_idx + IW'(1);

    always_comb begin
        n_phase = r_phase;
        n_sum   = r_sum;
        n_len   = r_len;
        n_idx   = r_idx;
        n_kind  = r_kind;
        n_slot  = r_slot;
        n_pwr   = r_pwr;
        n_cap   = r_cap;
        n_onoff = r_onoff;
        n_swlo  = r_swlo;
        n_swhi  = r_swhi;
        done    = 1'b0;
        ok      = 1'b0;
        case (r_phase)
            PH_DIR: begin
                if (i_rx_byte == r_dir_code) begin
                    n_sum   = sum_add;
                    n_phase = PH_LEN;
                end else begin
                    n_phase = PH_SYNC;
                end
            end
            PH_LEN: begin
                if (len_raw > 8'(MAX_PAYLOAD)) begin
                    n_len = IW'(MAX_PAYLOAD);
                end else begin
                    n_len = len_raw[IW-1:0];
                end
                n_sum   = sum_add;
                n_phase = PH_TYPE;
                // sync in this slot restarts the frame
                if (i_rx_byte == r_sync_byte) begin
                    n_sum   = i_rx_byte;
                    n_phase = PH_DIR;
                end
            end
            PH_TYPE: begin
                n_kind  = i_rx_byte;
                n_sum   = sum_add;
                n_idx   = '0;
                n_phase = PH_DATA;
                if (i_rx_byte == r_sync_byte) begin
                    n_sum   = i_rx_byte;
                    n_phase = PH_DIR;
                end
            end
            PH_DATA: begin
                n_sum = sum_add;
                for (int k = 0; k < KEEP_N; k++) begin
                    if (r_idx == IW'(KEEP_POS[k])) begin
                        n_slot[k] = i_rx_byte;
                    end
                end
                n_idx = idx_inc;
                if (idx_inc >= r_len) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                done    = 1'b1;
                n_phase = PH_SYNC;
                if (i_rx_byte == r_sum) begin
                    ok = 1'b1;
                    case (r_kind)
                        KIND_STATUS: begin
                            n_swlo = {r_slot[SLOT_P3], r_slot[SLOT_P2]};
                            n_swhi = {r_slot[SLOT_P5], r_slot[SLOT_P4]};
                            n_pwr  = {r_slot[SLOT_P13], r_slot[SLOT_P12]};
                        end
                        KIND_ONOFF: begin
                            n_cap   = {r_slot[SLOT_P11], r_slot[SLOT_P10]};
                            n_onoff = {r_slot[SLOT_P17], r_slot[SLOT_P16]};
                        end
                        KIND_POWER: begin
                            n_pwr = {r_slot[SLOT_P1], r_slot[SLOT_P0]};
                        end
                        KIND_CAPACITY: begin
                            n_cap = {r_slot[SLOT_P1], r_slot[SLOT_P0]};
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                if (i_rx_byte == r_sync_byte) begin
                    n_sum   = i_rx_byte;
                    n_phase = PH_DIR;
                end
            end
        endcase
    end

    always_comb begin
        o_result.frame_done         = done;
        o_result.frame_ok           = ok;
        o_result.power_state        = n_pwr;
        o_result.remaining_capacity = n_cap;
        o_result.on_off_state       = n_onoff;
        o_result.software_word_low  = n_swlo;
        o_result.software_word_high = n_swhi;
        o_result.ac_present         = n_pwr[2];
        o_result.battery_present    = n_pwr[0];
        if (!n_pwr[0]) begin
            o_result.charge_status = CHARGE_NO_BATT;
        end else if (n_cap < CAP_FULL) begin
            o_result.charge_status = CHARGE_CHARGING;
        end else begin
            o_result.charge_status = CHARGE_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte <= '0;
            r_dir_code  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SYNC: r_sync_byte <= i_cfg_data;
                CFG_DIR:  r_dir_code  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC;
            r_sum   <= '0;
            r_len   <= '0;
            r_idx   <= '0;
            r_kind  <= '0;
            r_pwr   <= '0;
            r_cap   <= '0;
            r_onoff <= '0;
            r_swlo  <= '0;
            r_swhi  <= '0;
            for (int k = 0; k < KEEP_N; k++) begin
                r_slot[k] <= '0;
            end
        end else if (i_acc) begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_kind  <= n_kind;
            r_pwr   <= n_pwr;
            r_cap   <= n_cap;
            r_onoff <= n_onoff;
            r_swlo  <= n_swlo;
            r_swhi  <= n_swhi;
            r_slot  <= n_slot;
        end
    end

endmodule

### hw/rtl/psfr_out_buf.sv
// Output register with one skid entry so the input can take one more
// result after the receiver stalls. Uses psfr_pkg for the result type.
module psfr_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_full,
    input  psfr_pkg::t_result i_result,
    output logic              o_valid,
    input  logic              i_stall,
    output psfr_pkg::t_result o_result
);
    import psfr_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    take;
    logic    acc;

    assign take    = r_out_valid & ~i_stall;
    assign acc     = i_valid & ~r_skid_valid;
    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            // output slot frees: refill from skid first, then from input
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= acc;
            end
        end else if (acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (acc) begin
                r_out <= i_result;
            end
        end else if (acc) begin
            r_skid <= i_result;
        end
    end

endmodule

### tb/psfr_checker.sv
// Checker for the power status frame receiver: predicts one result per accepted byte
// and compares every accepted result field by field. Depends on psfr_pkg.
module psfr_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  psfr_pkg::t_result i_result,
    output int                o_mismatches,
    output int                o_pending,
    output int                o_frames_good,
    output int                o_frames_bad
);
    timeunit 1ns;
    timeprecision 1ps;
    import psfr_pkg::*;

    localparam int PAY_MAX = 50;

    typedef enum logic [2:0] {
        WAIT_SYNC, GET_DIR, GET_LEN, GET_KIND, GET_DATA, GET_CHECK
    } t_phase;

    logic [7:0]  sync_cfg;
    logic [7:0]  dir_cfg;
    t_phase      phase;
    logic [7:0]  sum;
    logic [5:0]  pay_len;
    logic [5:0]  pay_idx;
    logic [7:0]  kind;
    logic [7:0]  pay_bytes [PAY_MAX];
    logic [15:0] power_word;
    logic [15:0] cap_word;
    logic [15:0] onoff_word;
    logic [15:0] swlo_word;
    logic [15:0] swhi_word;

    t_result     expected_results [$];
    int          mismatches;
    int          frames_good;
    int          frames_bad;
    int          pending_q;

    assign o_mismatches  = mismatches;
    assign o_pending     = pending_q;
    assign o_frames_good = frames_good;
    assign o_frames_bad  = frames_bad;

    initial begin
        mismatches  = 0;
        frames_good = 0;
        frames_bad  = 0;
        pending_q   = 0;
    end

    function automatic logic [15:0] pay_word(input int pos);
        return {pay_bytes[pos + 1], pay_bytes[pos]};
    endfunction

    // One parser step: update the parse state, status words and frame counts, return the result.
    function automatic t_result predict_byte(input logic [7:0] b);
        t_result    r;
        logic [7:0] wrapped;
        r = '0;
        case (phase)
            GET_DIR: begin
                if (b == dir_cfg) begin
                    sum   = sum + b;
                    phase = GET_LEN;
                end else begin
                    phase = WAIT_SYNC;
                end
            end
            GET_LEN: begin
                wrapped = b - 8'd2;
                pay_len = (wrapped > PAY_MAX) ? 6'(PAY_MAX) : wrapped[5:0];
                sum     = sum + b;
                phase   = GET_KIND;
                if (b == sync_cfg) begin
                    sum   = b;
                    phase = GET_DIR;
                end
            end
            GET_KIND: begin
                kind    = b;
                sum     = sum + b;
                pay_idx = '0;
                phase   = GET_DATA;
                if (b == sync_cfg) begin
                    sum   = b;
                    phase = GET_DIR;
                end
            end
            GET_DATA: begin
                sum = sum + b;
                if (pay_idx < PAY_MAX) pay_bytes[pay_idx] = b;
                if (pay_idx < 6'd63) pay_idx = pay_idx + 6'd1;
                if (pay_idx >= pay_len) phase = GET_CHECK;
            end
            GET_CHECK: begin
                r.frame_done = 1'b1;
                if (b == sum) begin
                    r.frame_ok = 1'b1;
                    frames_good++;
                    case (kind)
                        KIND_STATUS: begin
                            swlo_word  = pay_word(2);
                            swhi_word  = pay_word(4);
                            power_word = pay_word(12);
                        end
                        KIND_ONOFF: begin
                            cap_word   = pay_word(10);
                            onoff_word = pay_word(16);
                        end
                        KIND_POWER:    power_word = pay_word(0);
                        KIND_CAPACITY: cap_word = pay_word(0);
                        default: ;
                    endcase
                end else begin
                    frames_bad++;
                end
                phase = WAIT_SYNC;
            end
            default: begin
                if (b == sync_cfg) begin
                    sum   = b;
                    phase = GET_DIR;
                end
            end
        endcase
        r.power_state        = power_word;
        r.remaining_capacity = cap_word;
        r.on_off_state       = onoff_word;
        r.software_word_low  = swlo_word;
        r.software_word_high = swhi_word;
        r.ac_present         = power_word[2];
        r.battery_present    = power_word[0];
        if (power_word[0]) begin
            r.charge_status = (cap_word < CAP_FULL) ? CHARGE_CHARGING : CHARGE_FULL;
        end else begin
            r.charge_status = CHARGE_NO_BATT;
        end
        return r;
    endfunction

    task automatic cmp_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
        if (got !== want) begin
            if (mismatches < 10) begin
                $display("%0t: %s expected %h, got %h", $realtime, field, want, got);
            end
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            sync_cfg   = '0;
            dir_cfg    = '0;
            phase      = WAIT_SYNC;
            sum        = '0;
            pay_len    = '0;
            pay_idx    = '0;
            kind       = '0;
            foreach (pay_bytes[i]) pay_bytes[i] = '0;
            power_word = '0;
            cap_word   = '0;
            onoff_word = '0;
            swlo_word  = '0;
            swhi_word  = '0;
            expected_results.delete();
        end else begin
            // Compare first: a result never belongs to the byte taken at the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: result transaction with nothing expected", $realtime);
                    end
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    cmp_field("frame_done", 16'(want.frame_done), 16'(i_result.frame_done));
                    cmp_field("frame_ok", 16'(want.frame_ok), 16'(i_result.frame_ok));
                    cmp_field("power_state", want.power_state, i_result.power_state);
                    cmp_field("remaining_capacity", want.remaining_capacity,
                              i_result.remaining_capacity);
                    cmp_field("on_off_state", want.on_off_state, i_result.on_off_state);
                    cmp_field("software_word_low", want.software_word_low,
                              i_result.software_word_low);
                    cmp_field("software_word_high", want.software_word_high,
                              i_result.software_word_high);
                    cmp_field("ac_present", 16'(want.ac_present), 16'(i_result.ac_present));
                    cmp_field("battery_present", 16'(want.battery_present),
                              16'(i_result.battery_present));
                    cmp_field("charge_status", 16'(want.charge_status),
                              16'(i_result.charge_status));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(predict_byte(i_rx_byte));
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_SYNC) sync_cfg = i_cfg_data;
                else dir_cfg = i_cfg_data;
            end
        end
        pending_q <= expected_results.size();
    end

endmodule

### tb/tb_power_status_frame_receiver_top.sv
// Testbench top for the power status frame receiver: byte stimulus, output stalls,
// register settings and the verdict. Depends on psfr_pkg, the block and psfr_checker.
module tb_power_status_frame_receiver_top;
    timeunit 1ns;
    timeprecision 1ps;
    import psfr_pkg::*;

    localparam int PAY_MAX           = 50;
    localparam int N_SETTINGS        = 6;
    localparam int BYTES_PER_SETTING = 275;
    localparam int HOLD_CYCLES       = 60;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic        i_cfg_index  = CFG_SYNC;
    logic [7:0]  i_cfg_data   = '0;
    logic        i_in_valid   = 1'b0;
    logic [7:0]  i_rx_byte    = '0;
    logic        i_out_stall  = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_frame_done;
    logic        o_frame_ok;
    logic [15:0] o_power_state;
    logic [15:0] o_remaining_capacity;
    logic [15:0] o_on_off_state;
    logic [15:0] o_software_word_low;
    logic [15:0] o_software_word_high;
    logic        o_ac_present;
    logic        o_battery_present;
    logic [1:0]  o_charge_status;

    int          mismatches;
    int          pending;
    int          frames_good;
    int          frames_bad;

    logic [7:0]  sync_now;
    logic [7:0]  dir_now;
    int          bytes_sent   = 0;
    int          burst_left   = 0;
    bit          no_gaps      = 1'b0;
    bit          hold_off_req = 1'b0;

    power_status_frame_receiver_top DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_rx_byte           (i_rx_byte),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_frame_done        (o_frame_done),
        .o_frame_ok          (o_frame_ok),
        .o_power_state       (o_power_state),
        .o_remaining_capacity(o_remaining_capacity),
        .o_on_off_state      (o_on_off_state),
        .o_software_word_low (o_software_word_low),
        .o_software_word_high(o_software_word_high),
        .o_ac_present        (o_ac_present),
        .o_battery_present   (o_battery_present),
        .o_charge_status     (o_charge_status)
    );

    psfr_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_rx_byte    (i_rx_byte),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_result     ({o_frame_done, o_frame_ok, o_power_state, o_remaining_capacity,
                        o_on_off_state, o_software_word_low, o_software_word_high,
                        o_ac_present, o_battery_present, o_charge_status}),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_frames_good(frames_good),
        .o_frames_bad (frames_bad)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Output stalls: random segments of free flow, light, heavy and alternating
    // stall, plus one long hold-off on request.
    initial begin
        int seg_left;
        int mode;
        int hold_left;
        seg_left  = 0;
        mode      = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(10, 120);
                end
                seg_left--;
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= ~i_out_stall;
                endcase
            end
        end
    end

    // Offer one byte and hold it until the block takes it; bursts with gaps between.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0 && !no_gaps) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [7:0] sync_val, input logic [7:0] dir_val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SYNC;
        i_cfg_data  <= sync_val;
        @(posedge i_clk);
        i_cfg_index <= CFG_DIR;
        i_cfg_data  <= dir_val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Send one frame; restart_slot 1 or 2 puts a sync byte in the length or type slot
    // first, which restarts the frame (and its checksum) at that byte.
    task automatic send_frame(input logic [7:0] kind, input logic [7:0] len_byte,
                              input bit good_sum, input int restart_slot);
        logic [7:0]  sum;
        logic [7:0]  wrapped;
        logic [7:0]  pay [PAY_MAX];
        logic [15:0] near_full;
        int          n;
        wrapped = len_byte - 8'd2;
        n = (wrapped > PAY_MAX) ? PAY_MAX : int'(wrapped);
        if (n == 0) n = 1;
        foreach (pay[i]) pay[i] = 8'($urandom);
        // steer capacity words around the full mark now and then
        if ($urandom_range(0, 3) == 0) begin
            near_full = CAP_FULL + 16'($urandom_range(0, 2)) - 16'd1;
            if (kind == KIND_CAPACITY) {pay[1], pay[0]} = near_full;
            else if (kind == KIND_ONOFF) {pay[11], pay[10]} = near_full;
        end
        push_byte(sync_now);
        push_byte(dir_now);
        if (restart_slot == 1) begin
            push_byte(sync_now);
            push_byte(dir_now);
        end else if (restart_slot == 2) begin
            push_byte(8'($urandom_range(3, 40)));
            push_byte(sync_now);
            push_byte(dir_now);
        end
        sum = sync_now + dir_now + len_byte + kind;
        push_byte(len_byte);
        push_byte(kind);
        for (int i = 0; i < n; i++) begin
            push_byte(pay[i]);
            sum = sum + pay[i];
        end
        push_byte(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
    endtask

    initial begin
        int          phase_start;
        int          pick;
        logic [7:0]  kind;
        logic [7:0]  len_byte;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < N_SETTINGS; ph++) begin
            wait_drain();
            case (ph)
                0: begin sync_now = 8'hAA; dir_now = 8'h55; end
                1: begin sync_now = 8'h00; dir_now = 8'hFF; end
                2: begin sync_now = 8'hFF; dir_now = 8'h00; end
                3: begin sync_now = 8'h5A; dir_now = 8'h5A; end
                default: begin sync_now = 8'($urandom); dir_now = 8'($urandom); end
            endcase
            apply_setting(sync_now, dir_now);
            phase_start = bytes_sent;

            if (ph == 0) begin
                // noise at both extremes
                push_byte(8'h00);
                push_byte(8'hFF);
                // sync then a wrong direction byte that is itself the sync value
                push_byte(8'hAA);
                push_byte(8'hAA);
                // sync in the length slot, then in the type slot, then a power frame
                // with length 2, which still takes one payload byte
                push_byte(8'hAA);
                push_byte(8'h55);
                push_byte(8'hAA);
                push_byte(8'h55);
                push_byte(8'h03);
                push_byte(8'hAA);
                push_byte(8'h55);
                push_byte(8'h02);
                push_byte(KIND_POWER);
                push_byte(8'h05);
                push_byte(8'h0A);
                // capacity above full with a battery present
                push_byte(8'hAA);
                push_byte(8'h55);
                push_byte(8'h04);
                push_byte(KIND_CAPACITY);
                push_byte(8'hFF);
                push_byte(8'hFF);
                push_byte(8'h13);
                // type with no update whose good checksum equals the sync byte,
                // followed by the direction byte, which must stay noise
                push_byte(8'hAA);
                push_byte(8'h55);
                push_byte(8'h02);
                push_byte(8'h02);
                push_byte(8'hA7);
                push_byte(8'hAA);
                push_byte(8'h55);
            end

            if (ph == 1) begin
                // hold the output for a long stretch while a long frame keeps coming
                hold_off_req = 1'b1;
                no_gaps      = 1'b1;
                send_frame(KIND_POWER, 8'd52, 1'b1, 0);
                no_gaps      = 1'b0;
            end

            while (bytes_sent - phase_start < BYTES_PER_SETTING) begin
                pick = $urandom_range(0, 19);
                if (pick < 16) begin
                    case ($urandom_range(0, 9))
                        0, 1: kind = KIND_STATUS;
                        2, 3: kind = KIND_ONOFF;
                        4, 5: kind = KIND_POWER;
                        6, 7: kind = KIND_CAPACITY;
                        8: kind = $urandom_range(0, 1) ? 8'h02 : 8'h13;
                        default: kind = 8'($urandom);
                    endcase
                    case ($urandom_range(0, 19))
                        0: len_byte = 8'($urandom_range(0, 2));
                        1: len_byte = 8'($urandom_range(52, 255));
                        default: begin
                            if (kind == KIND_STATUS || kind == KIND_ONOFF) begin
                                len_byte = 8'($urandom_range(12, 22));
                            end else begin
                                len_byte = 8'($urandom_range(3, 12));
                            end
                        end
                    endcase
                    send_frame(kind, len_byte, $urandom_range(0, 7) != 0,
                               ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
                end else if (pick == 16) begin
                    push_byte(sync_now);
                    push_byte(dir_now ^ 8'($urandom_range(1, 255)));
                end else if (pick == 17) begin
                    // frame cut short; the next bytes land in its payload
                    push_byte(sync_now);
                    push_byte(dir_now);
                    push_byte(8'($urandom_range(8, 30)));
                    push_byte(KIND_POWER);
                end else begin
                    repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
                end
            end
        end

        wait_drain();
        repeat (4) @(posedge i_clk);
        $display("Sent %0d bytes under %0d sync/direction settings,",
                 bytes_sent, N_SETTINGS);
        $display("with a long output hold-off; frames closed: %0d good, %0d bad checksum.",
                 frames_good, frames_bad);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
